[rtl/llre_pkg.sv]
`default_nettype none

package llre_pkg;

  localparam int CMD_W         = 3;
  localparam int ITEM_W        = 11;
  localparam int LEN_W         = 11;
  localparam int SUM_W         = 20;
  localparam int IN_DATA_W     = 32;
  localparam int OUT_DATA_W    = 24;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_IDX_W     = CFG_ADDR_W - 2;
  localparam int MAX_ITEMS_DEF = 1024;
  localparam int UPC_W         = 6;

  localparam logic [LEN_W-1:0]     LEN_RESET       = LEN_W'(1024);
  localparam logic [CFG_IDX_W-1:0] REG_LIST_LENGTH = '0;

  typedef enum logic [CMD_W-1:0] {
    CMD_REBUILD = 3'd0,
    CMD_BEFORE  = 3'd1,
    CMD_AFTER   = 3'd2,
    CMD_SWAP    = 3'd3,
    CMD_REVERSE = 3'd4,
    CMD_QUERY   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_REBUILD,
    OP_BEFORE,
    OP_AFTER,
    OP_SWAP,
    OP_REVERSE,
    OP_QUERY
  } op_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_A,
    RD_B,
    RD_ZERO,
    RD_NEXTQ
  } rd_src_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_ALAR,
    DP_BL,
    DP_BR,
    DP_BLBR,
    DP_SWAP_IF,
    DP_TOGGLE,
    DP_SWEEP_INIT,
    DP_SWEEP_STEP,
    DP_QINIT,
    DP_QSTEP
  } dp_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_JOIN,
    WR_SWEEP
  } wr_mode_t;

  typedef enum logic [2:0] {
    SRC_A,
    SRC_B,
    SRC_AL,
    SRC_AR,
    SRC_BL,
    SRC_BR
  } jsrc_t;

  typedef enum logic [2:0] {
    C_PREV_EQ_A,
    C_NEXT_EQ_B,
    C_NEXT_EQ_A,
    C_WALK_END,
    C_SWEEP_END,
    C_OUT_FREE
  } cond_sel_t;

  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_HIT,
    J_UNTIL,
    J_DISPATCH
  } jmp_t;

  typedef struct packed {
    rd_src_t          rd;
    dp_op_t           dp;
    wr_mode_t         wr;
    jsrc_t            jl;
    jsrc_t            jr;
    cond_sel_t        cond;
    jmp_t             jmp;
    logic             emit;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    op_t  op;
    logic prev_eq_a;
    logic next_eq_b;
    logic next_eq_a;
    logic walk_end;
    logic sweep_end;
    logic out_free;
  } flags_t;

endpackage

`default_nettype wire

[rtl/llre_link_ram.sv]
`default_nettype none

module llre_link_ram #(
  parameter int DEPTH = 1025,
  parameter int AW    = 11,
  parameter int DW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/llre_useq.sv]
`default_nettype none

module llre_useq (
  input  logic            clk,
  input  logic            rst_n,
  input  llre_pkg::flags_t flags,
  output llre_pkg::ctrl_t  ctrl
);

  import llre_pkg::*;

  localparam logic [UPC_W-1:0] UP_IDLE = UPC_W'(0);
  localparam logic [UPC_W-1:0] UP_RB0  = UPC_W'(1);
  localparam logic [UPC_W-1:0] UP_RB1  = UPC_W'(2);
  localparam logic [UPC_W-1:0] UP_RV   = UPC_W'(3);
  localparam logic [UPC_W-1:0] UP_PB0  = UPC_W'(4);
  localparam logic [UPC_W-1:0] UP_PB1  = UPC_W'(5);
  localparam logic [UPC_W-1:0] UP_PB2  = UPC_W'(6);
  localparam logic [UPC_W-1:0] UP_PB3  = UPC_W'(7);
  localparam logic [UPC_W-1:0] UP_PB4  = UPC_W'(8);
  localparam logic [UPC_W-1:0] UP_PB5  = UPC_W'(9);
  localparam logic [UPC_W-1:0] UP_PB6  = UPC_W'(10);
  localparam logic [UPC_W-1:0] UP_PB7  = UPC_W'(11);
  localparam logic [UPC_W-1:0] UP_PA0  = UPC_W'(12);
  localparam logic [UPC_W-1:0] UP_PA1  = UPC_W'(13);
  localparam logic [UPC_W-1:0] UP_PA2  = UPC_W'(14);
  localparam logic [UPC_W-1:0] UP_PA3  = UPC_W'(15);
  localparam logic [UPC_W-1:0] UP_PA4  = UPC_W'(16);
  localparam logic [UPC_W-1:0] UP_PA5  = UPC_W'(17);
  localparam logic [UPC_W-1:0] UP_PA6  = UPC_W'(18);
  localparam logic [UPC_W-1:0] UP_SW0  = UPC_W'(19);
  localparam logic [UPC_W-1:0] UP_SW1  = UPC_W'(20);
  localparam logic [UPC_W-1:0] UP_SW2  = UPC_W'(21);
  localparam logic [UPC_W-1:0] UP_SW3  = UPC_W'(22);
  localparam logic [UPC_W-1:0] UP_SW4  = UPC_W'(23);
  localparam logic [UPC_W-1:0] UP_SW5  = UPC_W'(24);
  localparam logic [UPC_W-1:0] UP_SW6  = UPC_W'(25);
  localparam logic [UPC_W-1:0] UP_SW7  = UPC_W'(26);
  localparam logic [UPC_W-1:0] UP_SW8  = UPC_W'(27);
  localparam logic [UPC_W-1:0] UP_SW9  = UPC_W'(28);
  localparam logic [UPC_W-1:0] UP_AJ0  = UPC_W'(29);
  localparam logic [UPC_W-1:0] UP_AJ1  = UPC_W'(30);
  localparam logic [UPC_W-1:0] UP_AJ2  = UPC_W'(31);
  localparam logic [UPC_W-1:0] UP_AJ3  = UPC_W'(32);
  localparam logic [UPC_W-1:0] UP_AJ4  = UPC_W'(33);
  localparam logic [UPC_W-1:0] UP_Q0   = UPC_W'(34);
  localparam logic [UPC_W-1:0] UP_Q1   = UPC_W'(35);
  localparam logic [UPC_W-1:0] UP_Q2   = UPC_W'(36);

  localparam ctrl_t CW_NOP = '{
    rd: RD_NONE, dp: DP_NONE, wr: WR_NONE, jl: SRC_A, jr: SRC_A,
    cond: C_PREV_EQ_A, jmp: J_NEXT, emit: 1'b0, target: UP_IDLE
  };

  function automatic ctrl_t join_word(input jsrc_t l, input jsrc_t r, input logic last);
    ctrl_t w;
    w    = CW_NOP;
    w.wr = WR_JOIN;
    w.jl = l;
    w.jr = r;
    if (last) begin
      w.jmp = J_GOTO;
    end
    return w;
  endfunction

  function automatic ctrl_t ucode(input logic [UPC_W-1:0] pc);
    ctrl_t w;
    w = CW_NOP;
    unique case (pc)
      UP_IDLE: w.jmp = J_DISPATCH;
      UP_RB0:  w.dp = DP_SWEEP_INIT;
      UP_RB1: begin
        w.wr   = WR_SWEEP;
        w.dp   = DP_SWEEP_STEP;
        w.cond = C_SWEEP_END;
        w.jmp  = J_UNTIL;
      end
      UP_RV: begin
        w.dp  = DP_TOGGLE;
        w.jmp = J_GOTO;
      end
      UP_PB0: w.rd = RD_B;
      UP_PB1: begin
        w.rd   = RD_A;
        w.cond = C_PREV_EQ_A;
        w.jmp  = J_HIT;
      end
      UP_PB2: w.dp = DP_ALAR;
      UP_PB3: w = join_word(SRC_AL, SRC_AR, 1'b0);
      UP_PB4: w.rd = RD_B;
      UP_PB5: w.dp = DP_BL;
      UP_PB6: w = join_word(SRC_BL, SRC_A, 1'b0);
      UP_PB7: w = join_word(SRC_A, SRC_B, 1'b1);
      UP_PA0: w.rd = RD_A;
      UP_PA1: begin
        w.dp   = DP_ALAR;
        w.cond = C_NEXT_EQ_B;
        w.jmp  = J_HIT;
      end
      UP_PA2: w = join_word(SRC_AL, SRC_AR, 1'b0);
      UP_PA3: w.rd = RD_B;
      UP_PA4: w.dp = DP_BR;
      UP_PA5: w = join_word(SRC_B, SRC_A, 1'b0);
      UP_PA6: w = join_word(SRC_A, SRC_BR, 1'b1);
      UP_SW0: w.rd = RD_B;
      UP_SW1: w.dp = DP_SWAP_IF;
      UP_SW2: w.rd = RD_A;
      UP_SW3: begin
        w.dp     = DP_ALAR;
        w.cond   = C_NEXT_EQ_B;
        w.jmp    = J_HIT;
        w.target = UP_AJ0;
      end
      UP_SW4: w.rd = RD_B;
      UP_SW5: w.dp = DP_BLBR;
      UP_SW6: w = join_word(SRC_BL, SRC_A, 1'b0);
      UP_SW7: w = join_word(SRC_A, SRC_BR, 1'b0);
      UP_SW8: w = join_word(SRC_AL, SRC_B, 1'b0);
      UP_SW9: w = join_word(SRC_B, SRC_AR, 1'b1);
      UP_AJ0: w.rd = RD_B;
      UP_AJ1: w.dp = DP_BR;
      UP_AJ2: w = join_word(SRC_B, SRC_A, 1'b0);
      UP_AJ3: w = join_word(SRC_AL, SRC_B, 1'b0);
      UP_AJ4: w = join_word(SRC_A, SRC_BR, 1'b1);
      UP_Q0: begin
        w.rd = RD_ZERO;
        w.dp = DP_QINIT;
      end
      UP_Q1: begin
        w.rd     = RD_NEXTQ;
        w.dp     = DP_QSTEP;
        w.cond   = C_WALK_END;
        w.jmp    = J_UNTIL;
        w.target = UP_Q2;
      end
      UP_Q2: begin
        w.emit = 1'b1;
        w.cond = C_OUT_FREE;
        w.jmp  = J_UNTIL;
      end
      default: w.jmp = J_GOTO;
    endcase
    return w;
  endfunction

  function automatic logic [UPC_W-1:0] entry(input op_t op);
    logic [UPC_W-1:0] pc;
    unique case (op)
      OP_REBUILD: pc = UP_RB0;
      OP_BEFORE:  pc = UP_PB0;
      OP_AFTER:   pc = UP_PA0;
      OP_SWAP:    pc = UP_SW0;
      OP_REVERSE: pc = UP_RV;
      OP_QUERY:   pc = UP_Q0;
      default:    pc = UP_IDLE;
    endcase
    return pc;
  endfunction

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  logic             hit;

  assign ctrl = ucode(upc_r);

  always_comb begin
    unique case (ctrl.cond)
      C_PREV_EQ_A: hit = flags.prev_eq_a;
      C_NEXT_EQ_B: hit = flags.next_eq_b;
      C_NEXT_EQ_A: hit = flags.next_eq_a;
      C_WALK_END:  hit = flags.walk_end;
      C_SWEEP_END: hit = flags.sweep_end;
      C_OUT_FREE:  hit = flags.out_free;
      default:     hit = 1'b0;
    endcase
  end

  always_comb begin
    unique case (ctrl.jmp)
      J_NEXT:     upc_nxt = upc_r + UPC_W'(1);
      J_GOTO:     upc_nxt = ctrl.target;
      J_HIT:      upc_nxt = hit ? ctrl.target : upc_r + UPC_W'(1);
      J_UNTIL:    upc_nxt = hit ? ctrl.target : upc_r;
      J_DISPATCH: upc_nxt = flags.accept ? entry(flags.op) : upc_r;
      default:    upc_nxt = UP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UP_RB0;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/linked_list_reorder_engine.sv]
// Channel  Dir  Handshake              Payload
// in_      in   in_tvalid/in_tready    in_tdata: command, item_a, item_b
// out_     out  out_tvalid/out_tready  out_tdata: odd_position_sum
// cfg_     in   APB, pready always 1   list_length at byte address 0
//
// An item is taken in the idle step; the sequencer then runs its program out of the
// microcode table, one step per cycle, with one read port and one write port per table.
// A move ends early when nothing moves; a reverse only toggles a direction flag; a query
// walks the links from the head; a rebuild sweeps entries 0 to MAX_ITEMS; bad items are dropped.
// After reset the tables are swept before in_tready rises.
// A query result waiting on out_tready holds the sequencer only if a second query ends.
`default_nettype none

module linked_list_reorder_engine #(
  parameter int MAX_ITEMS = llre_pkg::MAX_ITEMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // command[2:0], item_a[13:3], item_b[24:14], zero fill above
  input  logic [llre_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // odd_position_sum[19:0], zero fill above
  output logic [llre_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [llre_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [llre_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [llre_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  import llre_pkg::*;

  localparam int DEPTH = MAX_ITEMS + 1;
  localparam int LW    = $clog2(DEPTH);

  ctrl_t  ctrl;
  flags_t flags;

  logic [CMD_W-1:0]  in_cmd;
  logic [ITEM_W-1:0] in_a;
  logic [ITEM_W-1:0] in_b;
  logic              in_accept;
  logic              ab_ok;
  op_t               op_in;

  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  len_nxt;
  logic [ITEM_W-1:0] n_eff;
  logic [LW-1:0]     n_link;
  logic              cfg_wr;

  logic [LW-1:0]     a_r, a_nxt, b_r, b_nxt;
  logic [LW-1:0]     al_r, al_nxt, ar_r, ar_nxt, bl_r, bl_nxt, br_r, br_nxt;
  logic              rev_r, rev_nxt;
  logic [LW-1:0]     idx_r, idx_nxt;
  logic [ITEM_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SUM_W-1:0]  total_r, total_nxt;
  logic [SUM_W-1:0]  sum_fix;
  logic              out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]  out_data_r, out_data_nxt;
  logic              out_free;

  logic [ITEM_W:0]   n_p1;
  logic [2*ITEM_W:0] tri_prod;

  logic [LW-1:0]     nx_q, pv_q;
  logic              rd_en;
  logic [LW-1:0]     rd_addr;
  logic              nx_we, pv_we;
  logic [LW-1:0]     nx_waddr, nx_wdata, pv_waddr, pv_wdata;
  logic [LW-1:0]     jl_v, jr_v;
  logic [LW-1:0]     sw_next, sw_prev;

  function automatic logic [LW-1:0] pick(input jsrc_t s, input logic [LW-1:0] a,
                                         input logic [LW-1:0] b, input logic [LW-1:0] al,
                                         input logic [LW-1:0] ar, input logic [LW-1:0] bl,
                                         input logic [LW-1:0] br);
    logic [LW-1:0] v;
    unique case (s)
      SRC_A:   v = a;
      SRC_B:   v = b;
      SRC_AL:  v = al;
      SRC_AR:  v = ar;
      SRC_BL:  v = bl;
      SRC_BR:  v = br;
      default: v = a;
    endcase
    return v;
  endfunction

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready
                    & (cfg_paddr[CFG_ADDR_W-1:2] == REG_LIST_LENGTH);
  assign len_nxt    = cfg_wr ? cfg_pwdata[LEN_W-1:0] : len_r;
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == REG_LIST_LENGTH) ?
                      CFG_DATA_W'(len_r) : '0;

  always_comb begin
    if (len_r == '0) begin
      n_eff = ITEM_W'(1);
    end else if (int'(len_r) > MAX_ITEMS) begin
      n_eff = ITEM_W'(MAX_ITEMS);
    end else begin
      n_eff = len_r;
    end
  end

  assign n_link = LW'(n_eff);

  // input decode
  assign in_cmd    = in_tdata[CMD_W-1:0];
  assign in_a      = in_tdata[CMD_W +: ITEM_W];
  assign in_b      = in_tdata[CMD_W+ITEM_W +: ITEM_W];
  assign in_tready = (ctrl.jmp == J_DISPATCH);
  assign in_accept = in_tvalid & in_tready;
  assign ab_ok     = (in_a != '0) && (in_a <= n_eff) && (in_b != '0) && (in_b <= n_eff)
                   && (in_a != in_b);

  always_comb begin
    op_in = OP_NONE;
    unique case (in_cmd)
      CMD_REBUILD: op_in = OP_REBUILD;
      CMD_BEFORE:  if (ab_ok) op_in = rev_r ? OP_AFTER : OP_BEFORE;
      CMD_AFTER:   if (ab_ok) op_in = rev_r ? OP_BEFORE : OP_AFTER;
      CMD_SWAP:    if (ab_ok) op_in = OP_SWAP;
      CMD_REVERSE: op_in = OP_REVERSE;
      CMD_QUERY:   op_in = OP_QUERY;
      default:     op_in = OP_NONE;
    endcase
  end

  // sequencer
  assign out_free = ~out_valid_r | out_tready;

  always_comb begin
    flags.accept    = in_accept;
    flags.op        = op_in;
    flags.prev_eq_a = (pv_q == a_r);
    flags.next_eq_b = (nx_q == b_r);
    flags.next_eq_a = (nx_q == a_r);
    flags.walk_end  = (cnt_r == n_eff);
    flags.sweep_end = (idx_r == LW'(MAX_ITEMS));
    flags.out_free  = out_free;
  end

  llre_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // link tables
  llre_link_ram #(.DEPTH(DEPTH), .AW(LW), .DW(LW)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (nx_q)
  );

  llre_link_ram #(.DEPTH(DEPTH), .AW(LW), .DW(LW)) u_prev_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (pv_q)
  );

  assign rd_en = (ctrl.rd != RD_NONE);

  always_comb begin
    unique case (ctrl.rd)
      RD_A:     rd_addr = a_r;
      RD_B:     rd_addr = b_r;
      RD_ZERO:  rd_addr = '0;
      RD_NEXTQ: rd_addr = nx_q;
      default:  rd_addr = a_r;
    endcase
  end

  assign jl_v = pick(ctrl.jl, a_r, b_r, al_r, ar_r, bl_r, br_r);
  assign jr_v = pick(ctrl.jr, a_r, b_r, al_r, ar_r, bl_r, br_r);

  always_comb begin
    if (idx_r == '0) begin
      sw_next = LW'(1);
      sw_prev = n_link;
    end else if (idx_r <= n_link) begin
      sw_prev = idx_r - LW'(1);
      sw_next = (idx_r == n_link) ? '0 : idx_r + LW'(1);
    end else begin
      sw_next = '0;
      sw_prev = '0;
    end
  end

  always_comb begin
    nx_we    = 1'b0;
    pv_we    = 1'b0;
    nx_waddr = jl_v;
    nx_wdata = jr_v;
    pv_waddr = jr_v;
    pv_wdata = jl_v;
    unique case (ctrl.wr)
      WR_JOIN: begin
        nx_we = 1'b1;
        pv_we = 1'b1;
      end
      WR_SWEEP: begin
        nx_we    = 1'b1;
        pv_we    = 1'b1;
        nx_waddr = idx_r;
        nx_wdata = sw_next;
        pv_waddr = idx_r;
        pv_wdata = sw_prev;
      end
      default: begin
        nx_we = 1'b0;
        pv_we = 1'b0;
      end
    endcase
  end

  // datapath
  assign n_p1     = {1'b0, n_eff} + (ITEM_W+1)'(1);
  assign tri_prod = (2*ITEM_W+1)'(n_eff) * (2*ITEM_W+1)'(n_p1);
  assign sum_fix  = (rev_r && !n_eff[0]) ? total_r - sum_r : sum_r;

  always_comb begin
    a_nxt     = a_r;
    b_nxt     = b_r;
    al_nxt    = al_r;
    ar_nxt    = ar_r;
    bl_nxt    = bl_r;
    br_nxt    = br_r;
    rev_nxt   = rev_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    total_nxt = total_r;
    if (in_accept) begin
      a_nxt = LW'(in_a);
      b_nxt = LW'(in_b);
    end
    unique case (ctrl.dp)
      DP_ALAR: begin
        al_nxt = pv_q;
        ar_nxt = nx_q;
      end
      DP_BL: bl_nxt = pv_q;
      DP_BR: br_nxt = nx_q;
      DP_BLBR: begin
        bl_nxt = pv_q;
        br_nxt = nx_q;
      end
      DP_SWAP_IF: begin
        if (nx_q == a_r) begin
          a_nxt = b_r;
          b_nxt = a_r;
        end
      end
      DP_TOGGLE: rev_nxt = ~rev_r;
      DP_SWEEP_INIT: begin
        idx_nxt = '0;
        rev_nxt = 1'b0;
      end
      DP_SWEEP_STEP: idx_nxt = idx_r + LW'(1);
      DP_QINIT: begin
        sum_nxt   = '0;
        cnt_nxt   = ITEM_W'(1);
        total_nxt = tri_prod[SUM_W:1];
      end
      DP_QSTEP: begin
        if (cnt_r[0]) begin
          sum_nxt = sum_r + SUM_W'(nx_q);
        end
        cnt_nxt = cnt_r + ITEM_W'(1);
      end
      default: rev_nxt = rev_r;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (ctrl.emit && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = sum_fix;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= LEN_RESET;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      rev_r       <= rev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    al_r       <= al_nxt;
    ar_r       <= ar_nxt;
    bl_r       <= bl_nxt;
    br_r       <= br_nxt;
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    sum_r      <= sum_nxt;
    total_r    <= total_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);

`ifndef NO_ASSERTIONS
  a_reset_sweeps: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input taken before the link tables were swept");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !(nx_we || pv_we))
    else $error("link table written while idle");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.wr == WR_SWEEP) |-> (int'(idx_r) <= MAX_ITEMS))
    else $error("sweep ran past the table");

  a_join_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.wr == WR_JOIN) |-> (int'(jl_v) <= MAX_ITEMS && int'(jr_v) <= MAX_ITEMS))
    else $error("link written outside the table");
`endif

endmodule

`default_nettype wire
